// File: rtl/i2a_pkg.sv
// i2a_pkg: shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; used by every module under rtl/.
package i2a_pkg;

	localparam int unsigned VAL_W     = 16;
	localparam int unsigned NUM_DIGITS = 5;
	localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
	localparam int unsigned NUM_CELLS = VAL_W;
	localparam int unsigned MAX_CHARS = 6;
	localparam int unsigned CNT_W     = 3;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	typedef enum logic [1:0] {
		OP_SDEC = 2'd0,
		OP_UDEC = 2'd1,
		OP_HEXB = 2'd2,
		OP_HEXW = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             neg;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] mag;
		logic [BCD_W-1:0] bcd;
	} stage_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else begin
			ch = CH_UPPER_A + {4'd0, nib - 4'd10};
		end
		return ch;
	endfunction

endpackage

// File: rtl/i2a_cell.sv
// i2a_cell: one shift-and-add-3 step of the binary to BCD chain, registered.
// Depends on i2a_pkg.
module i2a_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  i2a_pkg::stage_t in_data,
	output logic            out_valid,
	output i2a_pkg::stage_t out_data
);

	i2a_pkg::stage_t          nxt;
	logic [i2a_pkg::BCD_W-1:0] adj;
	logic                     valid_q;
	i2a_pkg::stage_t          data_q;

	always_comb begin
		for (int i = 0; i < i2a_pkg::NUM_DIGITS; i++) begin
			if (in_data.bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = in_data.bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = in_data.bcd[4*i +: 4];
			end
		end
		nxt       = in_data;
		nxt.bcd   = {adj[i2a_pkg::BCD_W-2:0], in_data.mag[i2a_pkg::VAL_W-1]};
		nxt.mag   = {in_data.mag[i2a_pkg::VAL_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: rtl/i2a_serial.sv
// i2a_serial: builds the character run from the chain's result and sends it out
// one character per transfer. Depends on i2a_pkg.
module i2a_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  i2a_pkg::stage_t in_data,
	output logic            load_ok,
	output logic [7:0]      character,
	output logic            last,
	output logic            valid,
	input  logic            stall
);

	logic [7:0]                chars_q [i2a_pkg::MAX_CHARS];
	logic [i2a_pkg::CNT_W-1:0] rem_q;
	logic [7:0]                seq [i2a_pkg::MAX_CHARS];
	logic [i2a_pkg::CNT_W-1:0] cnt;
	logic [3:0]                dig [i2a_pkg::NUM_DIGITS];
	logic [2:0]                lz;
	logic [2:0]                off;
	logic [3:0]                pos;
	logic [3:0]                j;
	logic                      xfer;
	logic                      load;

	always_comb begin
		for (int i = 0; i < i2a_pkg::NUM_DIGITS; i++) begin
			dig[i] = in_data.bcd[4*(i2a_pkg::NUM_DIGITS-1-i) +: 4];
		end
		priority if (dig[0] != 4'd0) begin
			lz = 3'd0;
		end else if (dig[1] != 4'd0) begin
			lz = 3'd1;
		end else if (dig[2] != 4'd0) begin
			lz = 3'd2;
		end else if (dig[3] != 4'd0) begin
			lz = 3'd3;
		end else begin
			lz = 3'd4;
		end
		off = {2'd0, in_data.neg};
		for (int p = 0; p < i2a_pkg::MAX_CHARS; p++) begin
			seq[p] = i2a_pkg::CH_ZERO;
		end
		cnt = '0;
		pos = '0;
		j   = '0;
		unique case (in_data.op)
			i2a_pkg::OP_SDEC, i2a_pkg::OP_UDEC: begin
				if (in_data.neg) begin
					seq[0] = i2a_pkg::CH_MINUS;
				end
				for (int p = 0; p < i2a_pkg::MAX_CHARS; p++) begin
					pos = 4'(p) + {1'b0, lz};
					j   = pos - {1'b0, off};
					if (4'(p) >= {1'b0, off} && j < 4'(i2a_pkg::NUM_DIGITS)) begin
						seq[p] = i2a_pkg::hex_char(dig[j[2:0]]);
					end
				end
				cnt = 3'(i2a_pkg::NUM_DIGITS) - lz + off;
			end
			i2a_pkg::OP_HEXB: begin
				seq[0] = i2a_pkg::hex_char(in_data.value[7:4]);
				seq[1] = i2a_pkg::hex_char(in_data.value[3:0]);
				cnt    = 3'd2;
			end
			i2a_pkg::OP_HEXW: begin
				seq[0] = i2a_pkg::hex_char(in_data.value[15:12]);
				seq[1] = i2a_pkg::hex_char(in_data.value[11:8]);
				seq[2] = i2a_pkg::hex_char(in_data.value[7:4]);
				seq[3] = i2a_pkg::hex_char(in_data.value[3:0]);
				cnt    = 3'd4;
			end
			default: begin
				cnt = '0;
			end
		endcase
	end

	assign valid   = (rem_q != '0);
	assign last    = (rem_q == 3'd1);
	assign xfer    = valid && !stall;
	assign load_ok = (rem_q == '0) || (last && !stall);
	assign load    = in_valid && load_ok;
	assign character = chars_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= cnt;
		end else if (xfer) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int p = 0; p < i2a_pkg::MAX_CHARS; p++) begin
				chars_q[p] <= seq[p];
			end
		end else if (xfer) begin
			for (int p = 0; p < i2a_pkg::MAX_CHARS - 1; p++) begin
				chars_q[p] <= chars_q[p+1];
			end
		end
	end

endmodule

// File: rtl/integer_to_ascii_formatter_unit.sv
// integer_to_ascii_formatter_unit: top level; a 16-cell binary to BCD chain
// feeding the character serialiser. Depends on i2a_pkg, i2a_cell, i2a_serial.
//
//   channel | signals                      | direction | per transfer
//   item    | item_valid item_stall op value | in      | one value and mode
//   char    | char_valid char_stall character last | out | one ASCII character
//
// A value passes through the 16 cells of the chain (one shift step per cell),
// then leaves as 1 to 6 characters, one per cycle while char_stall is low; a
// value is taken every cycle while the chain has room, so over time values are
// taken no faster than their runs leave the serialiser's single output register.
// Reset clears only valid flags and the run counter. The chain moves only while
// its last cell is empty or the serialiser can take it; otherwise item_stall rises.
module integer_to_ascii_formatter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic [15:0] value,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  character,
	output logic        last
);

	logic            stg_valid [i2a_pkg::NUM_CELLS+1];
	i2a_pkg::stage_t stg_data  [i2a_pkg::NUM_CELLS+1];
	logic            load_ok;
	logic            adv;

	always_comb begin
		stg_valid[0]      = item_valid;
		stg_data[0].op    = i2a_pkg::op_t'(op);
		stg_data[0].neg   = (i2a_pkg::op_t'(op) == i2a_pkg::OP_SDEC) && value[15];
		stg_data[0].value = value;
		stg_data[0].mag   = stg_data[0].neg ? 16'(~value + 16'd1) : value;
		stg_data[0].bcd   = '0;
	end

	assign adv        = !stg_valid[i2a_pkg::NUM_CELLS] || load_ok;
	assign item_stall = !adv;

	for (genvar g = 0; g < i2a_pkg::NUM_CELLS; g++) begin : g_cell
		i2a_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (stg_valid[g]),
			.in_data   (stg_data[g]),
			.out_valid (stg_valid[g+1]),
			.out_data  (stg_data[g+1])
		);
	end

	i2a_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[i2a_pkg::NUM_CELLS]),
		.in_data   (stg_data[i2a_pkg::NUM_CELLS]),
		.load_ok   (load_ok),
		.character (character),
		.last      (last),
		.valid     (char_valid),
		.stall     (char_stall)
	);

	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && !last) |=> char_valid)
		else $error("character run broken before its last character");

	a_stall_needs_full_chain: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> stg_valid[i2a_pkg::NUM_CELLS])
		else $error("input stalled with an empty chain end");

	a_mag_drained: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid[i2a_pkg::NUM_CELLS] |-> (stg_data[i2a_pkg::NUM_CELLS].mag == '0))
		else $error("binary bits left after the last cell");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid[i2a_pkg::NUM_CELLS] |->
			(stg_data[i2a_pkg::NUM_CELLS].bcd[3:0] <= 4'd9) &&
			(stg_data[i2a_pkg::NUM_CELLS].bcd[7:4] <= 4'd9) &&
			(stg_data[i2a_pkg::NUM_CELLS].bcd[11:8] <= 4'd9) &&
			(stg_data[i2a_pkg::NUM_CELLS].bcd[15:12] <= 4'd9) &&
			(stg_data[i2a_pkg::NUM_CELLS].bcd[19:16] <= 4'd9))
		else $error("BCD digit out of range at chain end");

endmodule

// File: tb/integer_to_ascii_formatter_unit_tb.sv
// Self-checking testbench for integer_to_ascii_formatter_unit: drives values in all four modes,
// predicts each character run and checks every char transfer in order under random stalls.
// Depends on i2a_pkg and the formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_tb;

	class char_scoreboard;
		typedef struct packed {
			logic [7:0] ch;
			logic       last;
		} char_t;

		localparam logic [7:0] ASCII_ZERO = 8'h30;
		localparam logic [7:0] ASCII_A    = 8'h41;

		char_t expected_q[$];
		int    errors;
		int    values_taken;
		int    chars_checked;
		int    mode_count[4];

		function new();
			errors = 0;
			values_taken = 0;
			chars_checked = 0;
			foreach (mode_count[i]) mode_count[i] = 0;
		endfunction

		function logic [7:0] digit_char(logic [3:0] nib);
			if (nib < 4'd10) begin
				return ASCII_ZERO + 8'(nib);
			end
			return ASCII_A + 8'(nib - 4'd10);
		endfunction

		// expected run for one accepted value
		function void note_item(i2a_pkg::op_t mode, logic [15:0] v);
			int unsigned weights[4] = '{10000, 1000, 100, 10};
			logic [7:0]  run[$];
			logic [15:0] mag;
			int unsigned rem;
			int unsigned q;
			bit          lead;
			int          ndig;
			char_t       c;
			mag = v;
			lead = 1'b0;
			case (mode)
				i2a_pkg::OP_SDEC, i2a_pkg::OP_UDEC: begin
					if (mode == i2a_pkg::OP_SDEC && v[15]) begin
						run.push_back(i2a_pkg::CH_MINUS);
						mag = ~v + 16'd1;
					end
					rem = 32'(mag);
					for (int i = 0; i < 4; i++) begin
						q = rem / weights[i];
						if (q != 0 || lead) begin
							run.push_back(digit_char(4'(q)));
							lead = 1'b1;
						end
						rem = rem - q * weights[i];
					end
					run.push_back(digit_char(4'(rem)));
				end
				default: begin
					ndig = (mode == i2a_pkg::OP_HEXB) ? 2 : 4;
					for (int d = ndig - 1; d >= 0; d--) begin
						run.push_back(digit_char(v[d*4 +: 4]));
					end
				end
			endcase
			foreach (run[i]) begin
				c.ch = run[i];
				c.last = (i == run.size() - 1);
				expected_q.push_back(c);
			end
			values_taken++;
			mode_count[mode]++;
		endfunction

		function void check_char(logic [7:0] ch, logic l);
			char_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected char transfer: character=%h last=%b", $time, ch, l);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			chars_checked++;
			if (ch !== e.ch) begin
				$display("%0t: character mismatch: expected %h actual %h", $time, e.ch, ch);
				errors++;
			end
			if (l !== e.last) begin
				$display("%0t: last mismatch: expected %b actual %b", $time, e.last, l);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	localparam int HOLD_CYCLES = 120;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_stall;
	i2a_pkg::op_t op = i2a_pkg::OP_SDEC;
	logic [15:0]  value = 16'h0000;
	logic         char_valid;
	logic         char_stall = 1'b0;
	logic [7:0]   character;
	logic         last;

	char_scoreboard sb = new();
	bit             rx_idling = 1'b0;
	bit             hold_req = 1'b0;

	integer_to_ascii_formatter_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(3_000_000);
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end
		if (r < 92) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [15:0] pick_value();
		logic [15:0] tens[8] = '{16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
			16'd9999, 16'd10000};
		logic [15:0] edges[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5:       return 16'($urandom_range(0, 20));
			6:          return tens[$urandom_range(0, 7)];
			7:          return 16'h0000 - 16'($urandom_range(1, 200));
			8:          return edges[$urandom_range(0, 3)];
			default:    return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_item(i2a_pkg::op_t mode, logic [15:0] v, int unsigned gap);
		item_valid <= 1'b1;
		op <= mode;
		value <= v;
		do @(posedge clk); while (item_stall);
		sb.note_item(mode, v);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			op <= i2a_pkg::op_t'($urandom_range(0, 3));
			value <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random(int n, bit back_to_back);
		int unsigned gap;
		for (int i = 0; i < n; i++) begin
			gap = (back_to_back || $urandom_range(0, 1)) ? 0 : pick_gap();
			send_item(i2a_pkg::op_t'($urandom_range(0, 3)), pick_value(), gap);
		end
	endtask

	// receiver: random stalls, plus one long counted hold on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			int unsigned len;
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				char_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				char_stall <= 1'b0;
			end else if (rx_idling && $urandom_range(0, 99) < 35) begin
				len = pick_gap();
				char_stall <= 1'b1;
				repeat (len) @(negedge clk);
				char_stall <= 1'b0;
			end else begin
				char_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			sb.check_char(character, last);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, no idling on either side
		send_item(i2a_pkg::OP_SDEC, 16'h0000, 0);
		send_item(i2a_pkg::OP_SDEC, 16'h0001, 0);
		send_item(i2a_pkg::OP_SDEC, 16'h7FFF, 0);
		send_item(i2a_pkg::OP_SDEC, 16'h8000, 0);
		send_item(i2a_pkg::OP_SDEC, 16'hFFFF, 0);
		send_item(i2a_pkg::OP_SDEC, 16'h8001, 0);
		send_item(i2a_pkg::OP_SDEC, 16'hFFF6, 0);
		send_item(i2a_pkg::OP_SDEC, 16'd9, 0);
		send_item(i2a_pkg::OP_SDEC, 16'd10, 0);
		send_item(i2a_pkg::OP_UDEC, 16'h0000, 0);
		send_item(i2a_pkg::OP_UDEC, 16'hFFFF, 0);
		send_item(i2a_pkg::OP_UDEC, 16'd10000, 0);
		send_item(i2a_pkg::OP_UDEC, 16'd9999, 0);
		send_item(i2a_pkg::OP_UDEC, 16'd100, 0);
		send_item(i2a_pkg::OP_UDEC, 16'd7, 0);
		send_item(i2a_pkg::OP_HEXB, 16'hFF00, 0);
		send_item(i2a_pkg::OP_HEXB, 16'h00AB, 0);
		send_item(i2a_pkg::OP_HEXB, 16'h1234, 0);
		send_item(i2a_pkg::OP_HEXW, 16'h0000, 0);
		send_item(i2a_pkg::OP_HEXW, 16'hFFFF, 0);
		send_item(i2a_pkg::OP_HEXW, 16'h5AF3, 0);
		send_item(i2a_pkg::OP_HEXW, 16'hA5C9, 0);

		rx_idling = 1'b1;
		send_random(60, 1'b0);

		// long receiver hold while values keep coming, to back up the chain
		hold_req = 1'b1;
		send_random(25, 1'b1);

		send_random(60, 1'b0);

		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Formatted %0d values (signed %0d, unsigned %0d, hex byte %0d, hex word %0d);",
			sb.values_taken, sb.mode_count[i2a_pkg::OP_SDEC],
			sb.mode_count[i2a_pkg::OP_UDEC], sb.mode_count[i2a_pkg::OP_HEXB],
			sb.mode_count[i2a_pkg::OP_HEXW]);
		$display("%0d characters checked under random and long output stalls, %0d errors.",
			sb.chars_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
